>>> rtl/spv_pkg.sv
// Shared types and constants for the sample playback voice.
// Holds the request/response payload structs, mode and status codes and
// the controller state and command types. No dependencies.
package spv_pkg;

  // Default sizing, handed to the top level parameters
  localparam int SAMPLE_DEPTH_DEF = 65536;
  localparam int FRAC_BITS_DEF    = 16;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;
  localparam int STEP_W    = 24;
  localparam int MIX_W     = 24;

  // Item modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_START = 2'd1;
  localparam mode_t MODE_TICK  = 2'd2;

  // Voice status codes
  typedef logic [1:0] vstat_t;
  localparam vstat_t VS_INACTIVE = 2'd0;
  localparam vstat_t VS_WAITING  = 2'd1;
  localparam vstat_t VS_PLAYING  = 2'd2;

  typedef struct packed {
    mode_t                      mode;
    logic signed [SAMPLE_W-1:0] sample_word;
    logic                       last_word;
    logic signed [GAIN_W-1:0]   gain_in;
    logic [STEP_W-1:0]          step_in;
    logic signed [MIX_W-1:0]    mix_in;
  } req_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_out;
    vstat_t                  voice_status;
  } rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_FETCH,
    CS_MUL,
    CS_SCALE,
    CS_SUM,
    CS_EMIT
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decode;
    logic fetch;
    logic mul;
    logic scale;
    logic sum;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic tick_go;
    logic rsp_free;
  } dp_status_t;

endpackage

>>> rtl/sample_playback_voice_unit.sv
// Top level of the sample playback voice.
// Joins the spv_ctrl controller and the spv_datapath; depends on spv_pkg.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_t: mode, sample, gain, step, mix
//   rsp      out  rsp_valid/rsp_stall  rsp_t: mix_out, voice_status
//
// Load, start and idle ticks go through decode and emit; a playing tick adds
// fetch, multiply, scale and sum, set by the two sample reads on the single
// store read port and the interpolation and gain multiplies in series.
// Reset leaves the voice inactive with no sample; the store is not cleared.
// A stalled response is held in its register; the next item is taken
// meanwhile and its result waits until that register frees.
module sample_playback_voice_unit
  import spv_pkg::*;
#(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequencer
  spv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Store and arithmetic
  spv_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> rtl/spv_ctrl.sv
// Controller state machine for the sample playback voice.
// Sequences one item through decode and emit, adding sample fetch, multiply,
// scale and sum steps for a tick of a playing voice. Depends on spv_pkg.
module spv_ctrl
  import spv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      CS_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = CS_DECODE;
        end
      end
      CS_DECODE: begin
        cmd.decode = 1'b1;
        state_next = status.tick_go ? CS_FETCH : CS_EMIT;
      end
      CS_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = CS_MUL;
      end
      CS_MUL: begin
        cmd.mul    = 1'b1;
        state_next = CS_SCALE;
      end
      CS_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = CS_SUM;
      end
      CS_SUM: begin
        cmd.sum    = 1'b1;
        state_next = CS_EMIT;
      end
      CS_EMIT: begin
        // hold until the response register can take the result
        if (status.rsp_free) begin
          cmd.emit   = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/spv_datapath.sv
// Datapath for the sample playback voice: sample store, voice registers,
// interpolation multipliers, gain scaling, mix saturation, response register.
// Depends on spv_pkg; driven by spv_ctrl commands.
module spv_datapath
  import spv_pkg::*;
#(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  ctl_cmd_t   cmd,
  output dp_status_t status,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp
);

  localparam int AW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int LW  = AW + 1;
  localparam int IPW = (LW + FRAC_BITS > STEP_W) ? LW + FRAC_BITS : STEP_W;
  localparam int PW  = IPW + 1;
  localparam int XW  = PW - FRAC_BITS;
  localparam int IW  = FRAC_BITS + 18;
  localparam int PRW = IW + GAIN_W;
  localparam int SH  = FRAC_BITS + GAIN_FRAC;
  localparam int VW  = PRW - SH;
  localparam int SW  = MIX_W + 2;

  localparam logic [FRAC_BITS:0] ONE_W    = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [STEP_W:0]    ONE_STEP = (STEP_W + 1)'(1) << FRAC_BITS;
  localparam logic [LW-1:0]      DEPTH_L  = LW'(SAMPLE_DEPTH);
  localparam logic signed [PRW-1:0] RND   = PRW'(1) << (SH - 1);
  localparam logic signed [SW-1:0] MIX_MAX = SW'((1 << (MIX_W - 1)) - 1);
  localparam logic signed [SW-1:0] MIX_MIN = -SW'(1 << (MIX_W - 1));
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);

  // Sample store
  logic signed [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]              rd_addr;
  logic                       rd_en;
  logic                       wr_en;

  // Item and voice registers
  req_t                       item;
  logic [LW-1:0]              load_ptr;
  logic [LW-1:0]              sample_len;
  logic [PW-1:0]              phase;
  logic signed [GAIN_W-1:0]   voice_gain;
  logic [STEP_W-1:0]          voice_step;
  vstat_t                     voice_state;

  // Arithmetic registers
  logic signed [SAMPLE_W-1:0] s0;
  logic signed [IW-1:0]       p0;
  logic signed [IW-1:0]       p1;
  logic signed [PRW-1:0]      scaled;
  logic signed [MIX_W-1:0]    result;

  // Combinational terms
  logic [XW-1:0]              idx;
  logic [FRAC_BITS-1:0]       frac_w;
  logic [XW-1:0]              len_x;
  logic [PW-1:0]              bound;
  logic                       unity;
  logic                       at_end;
  logic [PW-1:0]              phase_next;
  logic                       end_next;
  logic [LW-1:0]              ptr_after;
  logic [FRAC_BITS:0]         omw;
  logic signed [FRAC_BITS+1:0] omw_s;
  logic signed [FRAC_BITS+1:0] w_s;
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [IW-1:0]       p0_next;
  logic signed [IW-1:0]       p1_next;
  logic signed [IW-1:0]       interp;
  logic signed [PRW-1:0]      scaled_next;
  logic signed [PRW-1:0]      sc_rnd;
  logic signed [VW-1:0]       voice_val;
  logic signed [SW-1:0]       mix_sum;
  logic signed [MIX_W-1:0]    mix_sat;

  // Phase split, end tests and next phase
  always_comb begin
    idx        = phase[PW-1:FRAC_BITS];
    frac_w     = phase[FRAC_BITS-1:0];
    len_x      = XW'(sample_len);
    bound      = (sample_len == '0) ? '0 : (PW'(sample_len - LW'(1)) << FRAC_BITS);
    unity      = ({1'b0, voice_step} == ONE_STEP);
    at_end     = unity ? (idx >= len_x) : (phase >= bound);
    phase_next = phase + PW'(voice_step);
    end_next   = unity ? (phase_next[PW-1:FRAC_BITS] >= len_x) : (phase_next >= bound);
    ptr_after  = (load_ptr < DEPTH_L) ? load_ptr + LW'(1) : load_ptr;
  end

  assign status.tick_go  = (item.mode == MODE_TICK) && (voice_state == VS_PLAYING) && !at_end;
  assign status.rsp_free = !rsp_valid || !rsp_stall;

  // Store access: lower sample at decode, upper sample at fetch
  assign rd_en   = cmd.decode || cmd.fetch;
  assign rd_addr = cmd.fetch ? idx[AW-1:0] + AW'(1) : idx[AW-1:0];
  assign wr_en   = cmd.decode && (item.mode == MODE_LOAD) && (load_ptr < DEPTH_L);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[load_ptr[AW-1:0]] <= item.sample_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Interpolation weights and products
  always_comb begin
    omw         = ONE_W - {1'b0, frac_w};
    omw_s       = $signed({1'b0, omw});
    w_s         = $signed({2'b00, frac_w});
    s1          = (frac_w != '0) ? rd_data : '0;
    p0_next     = s0 * omw_s;
    p1_next     = s1 * w_s;
    interp      = p0 + p1;
    scaled_next = interp * voice_gain;
  end

  // Round, scale down and saturate onto the mix
  always_comb begin
    sc_rnd    = scaled + RND;
    voice_val = $signed(sc_rnd[PRW-1:SH]);
    mix_sum   = SW'(item.mix_in) + SW'(voice_val);
    if (mix_sum > MIX_MAX) begin
      mix_sat = MIX_MAX[MIX_W-1:0];
    end else if (mix_sum < MIX_MIN) begin
      mix_sat = MIX_MIN[MIX_W-1:0];
    end else begin
      mix_sat = mix_sum[MIX_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
    if (cmd.fetch) begin
      s0 <= rd_data;
    end
    if (cmd.mul) begin
      p0 <= p0_next;
      p1 <= p1_next;
    end
    if (cmd.scale) begin
      scaled <= scaled_next;
    end
    if (cmd.decode) begin
      if (item.mode == MODE_TICK) begin
        result <= item.mix_in;
      end else begin
        result <= '0;
      end
    end
    if (cmd.sum) begin
      result <= mix_sat;
    end
    if (cmd.emit) begin
      rsp.mix_out      <= result;
      rsp.voice_status <= voice_state;
    end
  end

  // Voice control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr    <= '0;
      sample_len  <= '0;
      phase       <= '0;
      voice_gain  <= GAIN_ONE;
      voice_step  <= ONE_STEP[STEP_W-1:0];
      voice_state <= VS_INACTIVE;
    end else begin
      if (cmd.decode) begin
        case (item.mode)
          MODE_LOAD: begin
            if (item.last_word) begin
              sample_len <= ptr_after;
              load_ptr   <= '0;
              if (voice_state == VS_WAITING && ptr_after != '0) begin
                voice_state <= VS_PLAYING;
              end
            end else begin
              load_ptr <= ptr_after;
            end
          end
          MODE_START: begin
            voice_gain  <= item.gain_in;
            voice_step  <= item.step_in;
            phase       <= '0;
            voice_state <= (sample_len != '0) ? VS_PLAYING : VS_WAITING;
          end
          MODE_TICK: begin
            // drop a voice whose phase already sits at or past the end
            if (voice_state == VS_PLAYING && at_end) begin
              voice_state <= VS_INACTIVE;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.sum) begin
        phase <= phase_next;
        if (end_next) begin
          voice_state <= VS_INACTIVE;
        end
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    load_ptr <= DEPTH_L)
    else $error("load pointer beyond store depth");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    cmd.decode && item.mode == MODE_START |=>
      voice_state == VS_PLAYING || voice_state == VS_WAITING)
    else $error("start did not arm the voice");

  a_play_len: assert property (@(posedge clk) disable iff (rst)
    voice_state == VS_PLAYING |-> sample_len != '0)
    else $error("voice playing with no sample");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !rsp_valid || !rsp_stall)
    else $error("result overwrote a stalled response");
`endif

endmodule
